### hdl/dsc_pkg.sv
// ----------------------------------------------------------------------------
// dsc_pkg
// Shared widths, calendar constants, reciprocal factors and the time-of-day
// bundle used by the serial day to calendar converter.
// ----------------------------------------------------------------------------
package dsc_pkg;

  localparam int DAY_W  = 23;
  localparam int MS_W   = 27;
  localparam int ABS_W  = 22;
  localparam int YEAR_W = 14;

  // Supported serial range and the shift to days since 1 Jan of year 0
  localparam logic signed [DAY_W-1:0] SERIAL_MIN   = -23'sd657434;
  localparam logic signed [DAY_W-1:0] SERIAL_MAX   = 23'sd2958465;
  localparam logic [ABS_W-1:0]        EPOCH_OFFSET = 22'd693959;

  localparam logic [MS_W-1:0] MS_PER_DAY  = 27'd86400000;
  localparam logic [MS_W-1:0] MS_PER_HOUR = 27'd3600000;
  localparam logic [21:0]     MS_PER_MIN  = 22'd60000;
  localparam logic [15:0]     MS_PER_SEC  = 16'd1000;

  localparam logic [17:0] DAYS_400Y = 18'd146097;
  localparam logic [17:0] DAYS_100Y = 18'd36524;
  localparam logic [15:0] DAYS_4Y   = 16'd1461;
  localparam logic [10:0] DAYS_YEAR = 11'd365;

  // Floor reciprocals: the estimate is never high and at most one low
  // while the dividend stays below two to the shift.
  localparam int Q400_SH = 22;
  localparam logic [4:0]  Q400_MUL = 5'((2 ** Q400_SH) / 146097);
  localparam int WK_SH = 22;
  localparam logic [19:0] WK_MUL = 20'((2 ** WK_SH) / 7);
  localparam int Q4_SH = 16;
  localparam logic [5:0]  Q4_MUL = 6'((2 ** Q4_SH) / 1461);
  localparam int HOUR_SH = 27;
  localparam logic [5:0]  HOUR_MUL = 6'((2 ** HOUR_SH) / 3600000);
  localparam int MIN_SH = 22;
  localparam logic [6:0]  MIN_MUL = 7'((2 ** MIN_SH) / 60000);
  localparam int SEC_SH = 16;
  localparam logic [6:0]  SEC_MUL = 7'((2 ** SEC_SH) / 1000);

  // Days before the start of each month in a common year
  localparam logic [8:0] CUM_DAYS [13] = '{
    9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151, 9'd181,
    9'd212, 9'd243, 9'd273, 9'd304, 9'd334, 9'd365
  };

  typedef struct packed {
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
    logic [9:0] millisecond;
  } dsc_time_t;

endpackage

### hdl/dsc_clock.sv
// ----------------------------------------------------------------------------
// dsc_clock
// Six-stage split of milliseconds of the day into hour, minute, second and
// millisecond, each step a reciprocal estimate followed by one correction.
// ----------------------------------------------------------------------------
module dsc_clock import dsc_pkg::*; (
  input  logic            clk,
  input  logic [MS_W-1:0] ms_i,
  output dsc_time_t       tod_o
);

  // Stage 1: hour estimate
  logic [MS_W+5:0] h_prod;
  logic [MS_W-1:0] t1_r;
  logic [4:0]      h_est_r;

  // Stage 2: hour and remainder within the hour
  logic [MS_W-1:0] h_rem;
  logic [4:0]      hour_nxt;
  logic [21:0]     r1_nxt;
  logic [4:0]      hour2_r;
  logic [21:0]     r1_r;

  // Stage 3: minute estimate
  logic [28:0]     m_prod;
  logic [4:0]      hour3_r;
  logic [21:0]     r1b_r;
  logic [5:0]      m_est_r;

  // Stage 4: minute and remainder within the minute
  logic [21:0]     m_rem;
  logic [5:0]      minute_nxt;
  logic [15:0]     r2_nxt;
  logic [4:0]      hour4_r;
  logic [5:0]      min4_r;
  logic [15:0]     r2_r;

  // Stage 5: second estimate
  logic [22:0]     s_prod;
  logic [4:0]      hour5_r;
  logic [5:0]      min5_r;
  logic [15:0]     r2b_r;
  logic [5:0]      s_est_r;

  // Stage 6: second and millisecond
  logic [15:0]     s_rem;
  dsc_time_t       tod_nxt;
  dsc_time_t       tod_r;

  assign h_prod = (MS_W+6)'(ms_i) * (MS_W+6)'(HOUR_MUL);
  assign m_prod = 29'(r1_r) * 29'(MIN_MUL);
  assign s_prod = 23'(r2_r) * 23'(SEC_MUL);

  always_comb begin
    h_rem = t1_r - MS_W'(h_est_r) * MS_PER_HOUR;
    if (h_rem >= MS_PER_HOUR) begin
      hour_nxt = h_est_r + 5'd1;
      r1_nxt   = 22'(h_rem - MS_PER_HOUR);
    end else begin
      hour_nxt = h_est_r;
      r1_nxt   = 22'(h_rem);
    end
  end

  always_comb begin
    m_rem = r1b_r - 22'(m_est_r) * MS_PER_MIN;
    if (m_rem >= MS_PER_MIN) begin
      minute_nxt = m_est_r + 6'd1;
      r2_nxt     = 16'(m_rem - MS_PER_MIN);
    end else begin
      minute_nxt = m_est_r;
      r2_nxt     = 16'(m_rem);
    end
  end

  always_comb begin
    s_rem = r2b_r - 16'(s_est_r) * MS_PER_SEC;
    tod_nxt.hour   = hour5_r;
    tod_nxt.minute = min5_r;
    if (s_rem >= MS_PER_SEC) begin
      tod_nxt.second      = s_est_r + 6'd1;
      tod_nxt.millisecond = 10'(s_rem - MS_PER_SEC);
    end else begin
      tod_nxt.second      = s_est_r;
      tod_nxt.millisecond = 10'(s_rem);
    end
  end

  always_ff @(posedge clk) begin
    t1_r    <= ms_i;
    h_est_r <= 5'(h_prod >> HOUR_SH);

    hour2_r <= hour_nxt;
    r1_r    <= r1_nxt;

    hour3_r <= hour2_r;
    r1b_r   <= r1_r;
    m_est_r <= 6'(m_prod >> MIN_SH);

    hour4_r <= hour3_r;
    min4_r  <= minute_nxt;
    r2_r    <= r2_nxt;

    hour5_r <= hour4_r;
    min5_r  <= min4_r;
    r2b_r   <= r2_r;
    s_est_r <= 6'(s_prod >> SEC_SH);

    tod_r   <= tod_nxt;
  end

  assign tod_o = tod_r;

endmodule

### hdl/day_serial_to_calendar.sv
// ----------------------------------------------------------------------------
// day_serial_to_calendar
// Serial day (day 0 is 30 Dec 1899) plus milliseconds of the day to
// proleptic Gregorian date, time of day and weekday.
// ----------------------------------------------------------------------------
// A request is taken on every clock edge where start is high; busy never
// rises, so one request per cycle is sustained. Each request yields exactly
// one result, shown for a single cycle with out_strobe high, in request
// order, once it has passed the request register, stages 1 to 7 and the
// result register. The receiver cannot stall the block and has to take
// every result as it appears. The latency is set by the date path: a
// chain of reciprocal divisions by the 400-year and 4-year cycle lengths,
// each an estimate stage and a correction stage, followed by year and
// month resolution. Requests outside the supported range give
// out_valid_res low with every field zero.
// ----------------------------------------------------------------------------
module day_serial_to_calendar import dsc_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  output logic                    busy,
  input  logic signed [DAY_W-1:0] in_day_whole,
  input  logic [MS_W-1:0]         in_ms_of_day,
  output logic                    out_strobe,
  output logic                    out_valid_res,
  output logic [YEAR_W-1:0]       out_year,
  output logic [3:0]              out_month,
  output logic [4:0]              out_day_of_month,
  output logic [4:0]              out_hour,
  output logic [5:0]              out_minute,
  output logic [5:0]              out_second,
  output logic [9:0]              out_millisecond,
  output logic [2:0]              out_weekday
);

  logic accept;

  // Stage 0: request register
  logic                    s0_vld_r;
  logic signed [DAY_W-1:0] s0_day_r;
  logic [MS_W-1:0]         s0_ms_r;

  // Stage 1: range check, absolute day
  logic             in_range;
  logic             on_bound;
  logic             ok_nxt;
  logic [ABS_W-1:0] abs_nxt;
  logic             s1_vld_r;
  logic             s1_ok_r;
  logic [ABS_W-1:0] s1_abs_r;
  logic [ABS_W-1:0] s1_absm1_r;
  logic [MS_W-1:0]  s1_ms_r;

  // Stage 2: 400-year and weekday estimates
  logic [ABS_W+4:0]  q400_prod;
  logic [ABS_W+19:0] wk_prod;
  logic              s2_vld_r;
  logic              s2_ok_r;
  logic [ABS_W-1:0]  s2_abs_r;
  logic [ABS_W-1:0]  s2_absm1_r;
  logic [4:0]        s2_q400e_r;
  logic [18:0]       s2_wke_r;

  // Stage 3: 400-year quotient and remainder, weekday
  logic [ABS_W-1:0] r400_rem;
  logic [4:0]       q400_nxt;
  logic [17:0]      r400_nxt;
  logic [ABS_W-1:0] wk_rem;
  logic [2:0]       wday_nxt;
  logic             s3_vld_r;
  logic             s3_ok_r;
  logic [4:0]       s3_q400_r;
  logic [17:0]      s3_r400_r;
  logic [2:0]       s3_wday_r;

  // Stage 4: century within the 400-year cycle
  logic [1:0]  cent_nxt;
  logic [15:0] num_nxt;
  logic        s4_vld_r;
  logic        s4_ok_r;
  logic [4:0]  s4_q400_r;
  logic [1:0]  s4_cent_r;
  logic [15:0] s4_num_r;
  logic [2:0]  s4_wday_r;

  // Stage 5: 4-year estimate
  logic [21:0] q4_prod;
  logic        s5_vld_r;
  logic        s5_ok_r;
  logic [4:0]  s5_q400_r;
  logic [1:0]  s5_cent_r;
  logic [15:0] s5_num_r;
  logic [4:0]  s5_q4e_r;
  logic [2:0]  s5_wday_r;

  // Stage 6: 4-year quotient, day within the 4-year block
  logic [15:0] r4_rem;
  logic [4:0]  q4_nxt;
  logic [10:0] r4_nxt;
  logic        leap4_nxt;
  logic        s6_vld_r;
  logic        s6_ok_r;
  logic [4:0]  s6_q400_r;
  logic [1:0]  s6_cent_r;
  logic [4:0]  s6_q4_r;
  logic        s6_leap4_r;
  logic [10:0] s6_d4_r;
  logic [2:0]  s6_wday_r;

  // Stage 7: year within the block, day of year
  logic [1:0]        yr4_nxt;
  logic [10:0]       doy_wide;
  logic [YEAR_W-1:0] year_nxt;
  logic              s7_vld_r;
  logic              s7_ok_r;
  logic [YEAR_W-1:0] s7_year_r;
  logic              s7_leap_r;
  logic [8:0]        s7_doy_r;
  logic [2:0]        s7_wday_r;

  // Stage 8: month and day, result register
  dsc_time_t         tod;
  logic [8:0]        dy;
  logic [3:0]        mon_nxt;
  logic [3:0]        mon_idx;
  logic [4:0]        mday_nxt;
  logic              strobe_r;
  logic              valid_res_r;
  logic [YEAR_W-1:0] year_r;
  logic [3:0]        month_r;
  logic [4:0]        mday_r;
  dsc_time_t         tod_r;
  logic [2:0]        wday_r;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  dsc_clock u_clock (
    .clk   (clk),
    .ms_i  (s1_ms_r),
    .tod_o (tod)
  );

  // Stage 1
  always_comb begin
    in_range = (s0_day_r >= SERIAL_MIN) && (s0_day_r <= SERIAL_MAX) &&
               (s0_ms_r < MS_PER_DAY);
    on_bound = (s0_day_r == SERIAL_MIN) || (s0_day_r == SERIAL_MAX);
    ok_nxt   = in_range && !(on_bound && (s0_ms_r != '0));
    abs_nxt  = ABS_W'(s0_day_r) + EPOCH_OFFSET;
  end

  // Stage 2
  assign q400_prod = (ABS_W+5)'(s1_abs_r) * (ABS_W+5)'(Q400_MUL);
  assign wk_prod   = (ABS_W+20)'(s1_absm1_r) * (ABS_W+20)'(WK_MUL);

  // Stage 3: correct the estimates by one step at most
  always_comb begin
    r400_rem = s2_abs_r - ABS_W'(s2_q400e_r) * ABS_W'(DAYS_400Y);
    if (r400_rem >= ABS_W'(DAYS_400Y)) begin
      q400_nxt = s2_q400e_r + 5'd1;
      r400_nxt = 18'(r400_rem - ABS_W'(DAYS_400Y));
    end else begin
      q400_nxt = s2_q400e_r;
      r400_nxt = 18'(r400_rem);
    end
    wk_rem = s2_absm1_r - ABS_W'(s2_wke_r) * ABS_W'(7);
    if (wk_rem >= ABS_W'(7)) begin
      wday_nxt = 3'(wk_rem - ABS_W'(7)) + 3'd1;
    end else begin
      wday_nxt = 3'(wk_rem) + 3'd1;
    end
  end

  // Stage 4: the first century of a cycle is one day longer, so the
  // remainder after whole 36524-day centuries is the 4-year dividend
  always_comb begin
    cent_nxt = 2'd0;
    if (s3_r400_r >= 18'd36525)  cent_nxt = cent_nxt + 2'd1;
    if (s3_r400_r >= 18'd73049)  cent_nxt = cent_nxt + 2'd1;
    if (s3_r400_r >= 18'd109573) cent_nxt = cent_nxt + 2'd1;
    num_nxt = 16'(s3_r400_r - 18'(cent_nxt) * DAYS_100Y);
  end

  // Stage 5
  assign q4_prod = 22'(s4_num_r) * 22'(Q4_MUL);

  // Stage 6: first 4-year block of a non-leap century holds no leap day
  always_comb begin
    r4_rem = s5_num_r - 16'(s5_q4e_r) * DAYS_4Y;
    if (r4_rem >= DAYS_4Y) begin
      q4_nxt = s5_q4e_r + 5'd1;
      r4_nxt = 11'(r4_rem - DAYS_4Y);
    end else begin
      q4_nxt = s5_q4e_r;
      r4_nxt = 11'(r4_rem);
    end
    leap4_nxt = !((s5_cent_r != 2'd0) && (q4_nxt == 5'd0));
    if (!leap4_nxt) begin
      r4_nxt = r4_nxt - 11'd1;
    end
  end

  // Stage 7
  always_comb begin
    yr4_nxt = 2'd0;
    if (s6_leap4_r) begin
      if (s6_d4_r >= 11'd366)  yr4_nxt = yr4_nxt + 2'd1;
      if (s6_d4_r >= 11'd731)  yr4_nxt = yr4_nxt + 2'd1;
      if (s6_d4_r >= 11'd1096) yr4_nxt = yr4_nxt + 2'd1;
      if (yr4_nxt != 2'd0) begin
        doy_wide = s6_d4_r - 11'd1 - 11'(yr4_nxt) * DAYS_YEAR;
      end else begin
        doy_wide = s6_d4_r;
      end
    end else begin
      if (s6_d4_r >= 11'd365)  yr4_nxt = yr4_nxt + 2'd1;
      if (s6_d4_r >= 11'd730)  yr4_nxt = yr4_nxt + 2'd1;
      if (s6_d4_r >= 11'd1095) yr4_nxt = yr4_nxt + 2'd1;
      doy_wide = s6_d4_r - 11'(yr4_nxt) * DAYS_YEAR;
    end
    year_nxt = YEAR_W'(s6_q400_r) * YEAR_W'(400) + YEAR_W'(s6_cent_r) * YEAR_W'(100) +
               YEAR_W'({s6_q4_r, 2'b00}) + YEAR_W'(yr4_nxt);
  end

  // Stage 8: leap day first, then skip it and look up a common-year month
  always_comb begin
    dy      = 9'd0;
    mon_nxt = 4'd1;
    mon_idx = 4'd0;
    if (s7_leap_r && (s7_doy_r == 9'd59)) begin
      mon_nxt  = 4'd2;
      mday_nxt = 5'd29;
    end else begin
      dy = s7_doy_r + 9'd1;
      if (s7_leap_r && (s7_doy_r >= 9'd60)) begin
        dy = s7_doy_r;
      end
      for (int m = 1; m < 12; m++) begin
        if (dy > CUM_DAYS[m]) mon_nxt = mon_nxt + 4'd1;
      end
      mon_idx  = mon_nxt - 4'd1;
      mday_nxt = 5'(dy - CUM_DAYS[mon_idx]);
    end
  end

  // Valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r <= 1'b0;
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
      s4_vld_r <= 1'b0;
      s5_vld_r <= 1'b0;
      s6_vld_r <= 1'b0;
      s7_vld_r <= 1'b0;
      strobe_r <= 1'b0;
    end else begin
      s0_vld_r <= accept;
      s1_vld_r <= s0_vld_r;
      s2_vld_r <= s1_vld_r;
      s3_vld_r <= s2_vld_r;
      s4_vld_r <= s3_vld_r;
      s5_vld_r <= s4_vld_r;
      s6_vld_r <= s5_vld_r;
      s7_vld_r <= s6_vld_r;
      strobe_r <= s7_vld_r;
    end
  end

  // Payload pipeline
  always_ff @(posedge clk) begin
    s0_day_r   <= in_day_whole;
    s0_ms_r    <= in_ms_of_day;

    s1_ok_r    <= ok_nxt;
    s1_abs_r   <= abs_nxt;
    s1_absm1_r <= abs_nxt - ABS_W'(1);
    s1_ms_r    <= s0_ms_r;

    s2_ok_r    <= s1_ok_r;
    s2_abs_r   <= s1_abs_r;
    s2_absm1_r <= s1_absm1_r;
    s2_q400e_r <= 5'(q400_prod >> Q400_SH);
    s2_wke_r   <= 19'(wk_prod >> WK_SH);

    s3_ok_r    <= s2_ok_r;
    s3_q400_r  <= q400_nxt;
    s3_r400_r  <= r400_nxt;
    s3_wday_r  <= wday_nxt;

    s4_ok_r    <= s3_ok_r;
    s4_q400_r  <= s3_q400_r;
    s4_cent_r  <= cent_nxt;
    s4_num_r   <= num_nxt;
    s4_wday_r  <= s3_wday_r;

    s5_ok_r    <= s4_ok_r;
    s5_q400_r  <= s4_q400_r;
    s5_cent_r  <= s4_cent_r;
    s5_num_r   <= s4_num_r;
    s5_q4e_r   <= 5'(q4_prod >> Q4_SH);
    s5_wday_r  <= s4_wday_r;

    s6_ok_r    <= s5_ok_r;
    s6_q400_r  <= s5_q400_r;
    s6_cent_r  <= s5_cent_r;
    s6_q4_r    <= q4_nxt;
    s6_leap4_r <= leap4_nxt;
    s6_d4_r    <= r4_nxt;
    s6_wday_r  <= s5_wday_r;

    s7_ok_r    <= s6_ok_r;
    s7_year_r  <= year_nxt;
    s7_leap_r  <= s6_leap4_r && (yr4_nxt == 2'd0);
    s7_doy_r   <= 9'(doy_wide);
    s7_wday_r  <= s6_wday_r;

    // Drop every field of an out-of-range request to zero
    valid_res_r <= s7_ok_r;
    if (s7_ok_r) begin
      year_r  <= s7_year_r;
      month_r <= mon_nxt;
      mday_r  <= mday_nxt;
      tod_r   <= tod;
      wday_r  <= s7_wday_r;
    end else begin
      year_r  <= '0;
      month_r <= '0;
      mday_r  <= '0;
      tod_r   <= '0;
      wday_r  <= '0;
    end
  end

  assign out_strobe       = strobe_r;
  assign out_valid_res    = valid_res_r;
  assign out_year         = year_r;
  assign out_month        = month_r;
  assign out_day_of_month = mday_r;
  assign out_hour         = tod_r.hour;
  assign out_minute       = tod_r.minute;
  assign out_second       = tod_r.second;
  assign out_millisecond  = tod_r.millisecond;
  assign out_weekday      = wday_r;

endmodule

### dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Checks the serial day to calendar converter. A short table of requests
// covers the range bounds, out-of-range times, leap days and the negative
// zero day; random requests follow in three phases of sender idling. Every
// result is compared field by field with its typed value or a predictor.
// ----------------------------------------------------------------------------
module tb_top import dsc_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int ITEMS_PER_PHASE = 250;
  localparam int DRAIN_CYCLES = 20;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic              valid_res;
    logic [YEAR_W-1:0] year;
    logic [3:0]        month;
    logic [4:0]        day_of_month;
    logic [4:0]        hour;
    logic [5:0]        minute;
    logic [5:0]        second;
    logic [9:0]        millisecond;
    logic [2:0]        weekday;
  } calendar_t;

  typedef struct {
    logic signed [DAY_W-1:0] day;
    logic [MS_W-1:0]         ms;
    bit                      typed;
    calendar_t               res;
  } stim_row_t;

  localparam calendar_t NO_DATE = '0;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    start = 1'b0;
  logic signed [DAY_W-1:0] in_day_whole = '0;
  logic [MS_W-1:0]         in_ms_of_day = '0;
  logic                    busy;
  logic                    out_strobe;
  logic                    out_valid_res;
  logic [YEAR_W-1:0]       out_year;
  logic [3:0]              out_month;
  logic [4:0]              out_day_of_month;
  logic [4:0]              out_hour;
  logic [5:0]              out_minute;
  logic [5:0]              out_second;
  logic [9:0]              out_millisecond;
  logic [2:0]              out_weekday;

  // Typed expectation travelling with the current request
  bit        req_typed = 1'b0;
  calendar_t req_res = '0;

  calendar_t expected_dates[$];
  stim_row_t directed_rows[$];
  int        mismatch_count = 0;
  int        quiet_cycles = 0;

  day_serial_to_calendar uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_day_whole     (in_day_whole),
    .in_ms_of_day     (in_ms_of_day),
    .out_strobe       (out_strobe),
    .out_valid_res    (out_valid_res),
    .out_year         (out_year),
    .out_month        (out_month),
    .out_day_of_month (out_day_of_month),
    .out_hour         (out_hour),
    .out_minute       (out_minute),
    .out_second       (out_second),
    .out_millisecond  (out_millisecond),
    .out_weekday      (out_weekday)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic calendar_t predict_calendar(logic signed [DAY_W-1:0] day,
                                                 logic [MS_W-1:0] ms);
    calendar_t   r;
    int          d;
    int unsigned t;
    int          days;
    int          wday;
    int          q400;
    int          cent;
    int          q4;
    int          d4;
    int          yr4;
    bit          leap4;
    int          mon;
    d = int'(day);
    t = int'(ms);
    r = NO_DATE;
    if (d < int'(SERIAL_MIN) || d > int'(SERIAL_MAX) || t >= int'(MS_PER_DAY))
      return r;
    if ((d == int'(SERIAL_MIN) || d == int'(SERIAL_MAX)) && t != 0)
      return r;
    leap4 = 1'b1;
    days = d + int'(EPOCH_OFFSET);
    wday = ((days - 1) % 7) + 1;
    q400 = days / int'(DAYS_400Y);
    days = days % int'(DAYS_400Y);
    cent = (days == 0) ? 0 : (days - 1) / int'(DAYS_100Y);
    if (cent != 0) begin
      days = (days - 1) % int'(DAYS_100Y);
      q4 = (days + 1) / int'(DAYS_4Y);
      if (q4 != 0) begin
        d4 = (days + 1) % int'(DAYS_4Y);
      end else begin
        // first four years of a century other than the first are not leap
        leap4 = 1'b0;
        d4 = days;
      end
    end else begin
      q4 = days / int'(DAYS_4Y);
      d4 = days % int'(DAYS_4Y);
    end
    if (leap4) begin
      yr4 = (d4 == 0) ? 0 : (d4 - 1) / 365;
      if (yr4 != 0)
        d4 = (d4 - 1) % 365;
    end else begin
      yr4 = d4 / 365;
      d4 = d4 % 365;
    end
    if (yr4 == 0 && leap4 && d4 == 59) begin
      mon = 2;
      r.day_of_month = 5'd29;
    end else begin
      if (yr4 == 0 && leap4 && d4 >= 60)
        d4 = d4 - 1;
      d4 = d4 + 1;
      mon = 1;
      while (mon < 12 && d4 > int'(CUM_DAYS[mon]))
        mon = mon + 1;
      r.day_of_month = 5'(d4 - int'(CUM_DAYS[mon - 1]));
    end
    r.valid_res   = 1'b1;
    r.year        = YEAR_W'(q400 * 400 + cent * 100 + q4 * 4 + yr4);
    r.month       = 4'(mon);
    r.hour        = 5'(t / 3600000);
    r.minute      = 6'((t / 60000) % 60);
    r.second      = 6'((t / 1000) % 60);
    r.millisecond = 10'(t % 1000);
    r.weekday     = 3'(wday);
    return r;
  endfunction

  // Take requests and compare results; count cycles with no handshake
  always @(posedge clk) begin
    calendar_t got;
    calendar_t want;
    if (rst_n) begin
      if ((start && !busy) || out_strobe) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (start && !busy) begin
        expected_dates.push_back(req_typed ? req_res :
                                 predict_calendar(in_day_whole, in_ms_of_day));
      end
      if (out_strobe) begin
        got = '{out_valid_res, out_year, out_month, out_day_of_month, out_hour,
                out_minute, out_second, out_millisecond, out_weekday};
        if (expected_dates.size() == 0) begin
          mismatch_count <= mismatch_count + 1;
          if (mismatch_count < MAX_REPORTS)
            $display("%0t: result with no request waiting", $realtime);
        end else begin
          want = expected_dates.pop_front();
          if (got !== want) begin
            mismatch_count <= mismatch_count + 1;
            if (mismatch_count < MAX_REPORTS)
              $display("%0t: mismatch exp v%0d %0d-%0d-%0d %0d:%0d:%0d.%0d wd%0d", $realtime,
                       want.valid_res, want.year, want.month, want.day_of_month,
                       want.hour, want.minute, want.second, want.millisecond,
                       want.weekday,
                       " got v%0d %0d-%0d-%0d %0d:%0d:%0d.%0d wd%0d",
                       got.valid_res, got.year, got.month,
                       got.day_of_month, got.hour, got.minute, got.second,
                       got.millisecond, got.weekday);
          end
        end
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("tb_top NOT OK");
        $finish;
      end
    end
  end

  function automatic void add_row(int day, int unsigned ms, bit typed, calendar_t res);
    stim_row_t row;
    row.day = DAY_W'(day);
    row.ms = MS_W'(ms);
    row.typed = typed;
    row.res = res;
    directed_rows.push_back(row);
  endfunction

  // Drive one request and hold it until taken
  task automatic send_request(logic signed [DAY_W-1:0] day, logic [MS_W-1:0] ms,
                              bit typed, calendar_t res, int idle_pct);
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_day_whole <= day;
    in_ms_of_day <= ms;
    req_typed <= typed;
    req_res <= res;
    @(negedge clk);
    while (busy)
      @(negedge clk);
    @(posedge clk);
  endtask

  task automatic wait_for_results();
    start <= 1'b0;
    @(negedge clk);
    while (expected_dates.size() != 0)
      @(negedge clk);
    @(posedge clk);
  endtask

  task automatic pick_request(output logic signed [DAY_W-1:0] day,
                              output logic [MS_W-1:0] ms);
    int kind;
    int days;
    int d;
    kind = $urandom_range(0, 99);
    d = $urandom_range(0, int'(SERIAL_MAX) - int'(SERIAL_MIN)) + int'(SERIAL_MIN);
    ms = MS_W'($urandom_range(0, int'(MS_PER_DAY) - 1));
    if (kind >= 60 && kind < 80) begin
      // land near the edges of the 400, 100, 4 and 1 year cycles
      days = $urandom_range(0, 25) * int'(DAYS_400Y) + $urandom_range(0, 3) * int'(DAYS_100Y)
           + $urandom_range(0, 24) * int'(DAYS_4Y) + $urandom_range(0, 3) * 365
           + $urandom_range(0, 64) - 2;
      if (days - int'(EPOCH_OFFSET) >= int'(SERIAL_MIN) &&
          days - int'(EPOCH_OFFSET) <= int'(SERIAL_MAX))
        d = days - int'(EPOCH_OFFSET);
    end else if (kind >= 80 && kind < 85) begin
      d = $urandom_range(0, 1) ? int'(SERIAL_MAX) - $urandom_range(0, 1)
                               : int'(SERIAL_MIN) + $urandom_range(0, 1);
      if ($urandom_range(0, 1))
        ms = '0;
    end else if (kind >= 85 && kind < 92) begin
      case ($urandom_range(0, 3))
        0: ms = '0;
        1: ms = MS_PER_DAY - MS_W'(1);
        2: ms = MS_PER_DAY;
        default: ms = MS_W'($urandom_range(int'(MS_PER_DAY), 2 ** MS_W - 1));
      endcase
    end else if (kind >= 92) begin
      d = int'($signed(DAY_W'($urandom)));
      ms = MS_W'($urandom);
    end
    day = DAY_W'(d);
  endtask

  initial begin
    logic signed [DAY_W-1:0] day;
    logic [MS_W-1:0]         ms;
    int                      idle_pct;
    add_row(int'(SERIAL_MIN), 0, 1'b1, '{1'b1, 14'd100, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0,
                                         10'd0, 3'd6});
    add_row(int'(SERIAL_MAX), 0, 1'b1, '{1'b1, 14'd9999, 4'd12, 5'd31, 5'd0, 6'd0, 6'd0,
                                         10'd0, 3'd6});
    add_row(0, 0, 1'b1, '{1'b1, 14'd1899, 4'd12, 5'd30, 5'd0, 6'd0, 6'd0, 10'd0, 3'd7});
    add_row(int'(SERIAL_MIN), 1, 1'b1, NO_DATE);
    add_row(int'(SERIAL_MAX), 1, 1'b1, NO_DATE);
    add_row(int'(SERIAL_MIN) - 1, 0, 1'b1, NO_DATE);
    add_row(int'(SERIAL_MAX) + 1, 0, 1'b1, NO_DATE);
    add_row(-(2 ** (DAY_W - 1)), 0, 1'b1, NO_DATE);
    add_row(2 ** (DAY_W - 1) - 1, 2 ** MS_W - 1, 1'b1, NO_DATE);
    add_row(0, int'(MS_PER_DAY), 1'b1, NO_DATE);
    add_row(1, 2 ** MS_W - 1, 1'b1, NO_DATE);
    // negative zero day and a negative day with a fraction
    add_row(0, 43200000, 1'b0, NO_DATE);
    add_row(-1, 21600000, 1'b0, NO_DATE);
    add_row(1, int'(MS_PER_DAY) - 1, 1'b0, NO_DATE);
    add_row(int'(SERIAL_MIN) + 1, int'(MS_PER_DAY) - 1, 1'b0, NO_DATE);
    add_row(int'(SERIAL_MAX) - 1, int'(MS_PER_DAY) - 1, 1'b0, NO_DATE);
    // 1900 and 100 are not leap, 2000 is
    add_row(60, 0, 1'b0, NO_DATE);
    add_row(61, 0, 1'b0, NO_DATE);
    add_row(int'(SERIAL_MIN) + 58, 3599999, 1'b0, NO_DATE);
    add_row(int'(SERIAL_MIN) + 59, 0, 1'b0, NO_DATE);
    add_row(36584, 0, 1'b0, NO_DATE);
    add_row(36585, 59999, 1'b0, NO_DATE);
    add_row(36586, 0, 1'b0, NO_DATE);
    add_row(36891, 12345678, 1'b0, NO_DATE);
    add_row(36892, 999, 1'b0, NO_DATE);

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    foreach (directed_rows[i])
      send_request(directed_rows[i].day, directed_rows[i].ms, directed_rows[i].typed,
                   directed_rows[i].res, 12);
    wait_for_results();

    for (int phase = 0; phase < 3; phase++) begin
      idle_pct = (phase == 0) ? 12 : (phase == 1) ? 56 : 0;
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (n == ITEMS_PER_PHASE / 2)
          wait_for_results();
        pick_request(day, ms);
        send_request(day, ms, 1'b0, NO_DATE, idle_pct);
      end
      wait_for_results();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && expected_dates.size() == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
